// ----- rtl/core/mmms_pkg.sv -----
// shared widths, bin record type and sequencer states for the monthly stats block
`default_nettype none

package mmms_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TEMP_WIDTH  = 8;
   localparam int SUM_WIDTH   = COUNT_WIDTH + TEMP_WIDTH;
   localparam int NUM_BINS    = 13;
   localparam int BIN_WIDTH   = 4;
   localparam int MONTH_WIDTH = 4;

   localparam logic signed [TEMP_WIDTH-1:0] EMPTY_LOW  = TEMP_WIDTH'(99);
   localparam logic signed [TEMP_WIDTH-1:0] EMPTY_HIGH = TEMP_WIDTH'(-99);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0]  sum;
      logic [COUNT_WIDTH-1:0]       count;
      logic signed [TEMP_WIDTH-1:0] low;
      logic signed [TEMP_WIDTH-1:0] high;
      logic                         overflow;
   } bin_entry_type;

   localparam bin_entry_type EMPTY_ENTRY = '{
      sum:      '0,
      count:    '0,
      low:      EMPTY_LOW,
      high:     EMPTY_HIGH,
      overflow: 1'b0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/mmms_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned sum magnitude by count
`default_nettype none

module mmms_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [mmms_pkg::SUM_WIDTH-1:0]   dividend,
   input  wire logic [mmms_pkg::COUNT_WIDTH-1:0] divisor,
   output logic [mmms_pkg::SUM_WIDTH-1:0]        quotient,
   output logic                                  done
);
   import mmms_pkg::*;

   localparam int CNT_W = $clog2(SUM_WIDTH + 1);

   logic [SUM_WIDTH-1:0]   quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   running_ff, running_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH:0]   rem_shift;
   logic [COUNT_WIDTH:0]   trial;

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      rem_shift  = {rem_ff, quo_ff[SUM_WIDTH-1]};
      trial      = rem_shift - {1'b0, divisor_ff};
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         cnt_in     = CNT_W'(SUM_WIDTH);
         running_in = 1'b1;
      end else if (running_ff) begin
         if (!trial[COUNT_WIDTH]) begin
            rem_in = trial[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ----- rtl/core/monthly_min_max_mean_stats.sv -----
// top level: 13-bin temperature min/max/mean accumulator with report walk
//
//   channel   handshake          payload
//   req       start / busy       req_kind, req_month_number, req_temperature
//   rsp       rsp_strobe         rsp_bin_index .. rsp_last_bin, one cycle each
//
// a sample updates the year bin only, or the year bin and then its month bin: each
// bin is a read then a write of the single-port bin memory
// a report walks all 13 bins in turn; each bin is a read, a divider start, the 24
// quotient bits and the done from the shared divider, then the result cycle
// reset marks every bin empty at once through per-bin valid flops; a report
// clears them the same way after its last result
// results are presented for exactly one cycle and cannot be held off
`default_nettype none

module monthly_min_max_mean_stats (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_kind,
   input  wire logic [mmms_pkg::MONTH_WIDTH-1:0]        req_month_number,
   input  wire logic signed [mmms_pkg::TEMP_WIDTH-1:0]  req_temperature,
   output logic                                        rsp_strobe,
   output logic [mmms_pkg::BIN_WIDTH-1:0]               rsp_bin_index,
   output logic signed [mmms_pkg::TEMP_WIDTH-1:0]       rsp_mean_temp,
   output logic signed [mmms_pkg::TEMP_WIDTH-1:0]       rsp_lowest_temp,
   output logic signed [mmms_pkg::TEMP_WIDTH-1:0]       rsp_highest_temp,
   output logic [mmms_pkg::COUNT_WIDTH-1:0]             rsp_sample_count,
   output logic                                        rsp_saturated,
   output logic                                        rsp_last_bin
);
   import mmms_pkg::*;

   state_type state_ff, state_in;

   logic [BIN_WIDTH-1:0]         addr_ff, addr_in;
   logic [NUM_BINS-1:0]          valid_ff, valid_in;
   logic                         kind_ff, kind_in;
   logic [MONTH_WIDTH-1:0]       month_ff, month_in;
   logic signed [TEMP_WIDTH-1:0] temp_ff, temp_in;

   bin_entry_type                mem [NUM_BINS];
   bin_entry_type                rd_ff;
   bin_entry_type                cur;
   bin_entry_type                wr_data;
   logic                         wr_en;

   logic                         div_start;
   logic                         div_done;
   logic [SUM_WIDTH-1:0]         sum_mag;
   logic [SUM_WIDTH-1:0]         quotient;
   logic [SUM_WIDTH-1:0]         mean_full;
   logic signed [SUM_WIDTH-1:0]  temp_ext;
   logic                         month_bin;

   // bins never written since the last clear read as empty
   assign cur      = valid_ff[addr_ff] ? rd_ff : EMPTY_ENTRY;
   assign temp_ext = SUM_WIDTH'(temp_ff);
   assign sum_mag  = cur.sum[SUM_WIDTH-1] ? SUM_WIDTH'(-cur.sum) : SUM_WIDTH'(cur.sum);

   always_comb begin
      wr_data = cur;
      if (cur.count == '1) begin
         wr_data.overflow = 1'b1;
      end else begin
         if (cur.count == '0) begin
            wr_data.low  = temp_ff;
            wr_data.high = temp_ff;
         end else begin
            if (temp_ff < cur.low) begin
               wr_data.low = temp_ff;
            end
            if (temp_ff > cur.high) begin
               wr_data.high = temp_ff;
            end
         end
         wr_data.sum   = cur.sum + temp_ext;
         wr_data.count = cur.count + COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      month_bin  = (month_ff inside {[4'd1:4'd12]});
      state_in   = state_ff;
      addr_in    = addr_ff;
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      month_in   = month_ff;
      temp_in    = temp_ff;
      wr_en      = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               month_in = req_month_number;
               temp_in  = req_temperature;
               addr_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (kind_ff == KIND_REPORT) ? ST_DIV_GO : ST_UPDATE;
         end
         ST_UPDATE: begin
            wr_en             = 1'b1;
            valid_in[addr_ff] = 1'b1;
            if (addr_ff == '0 && month_bin) begin
               addr_in  = BIN_WIDTH'(month_ff);
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (addr_ff == BIN_WIDTH'(NUM_BINS - 1)) begin
               valid_in = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in  = addr_ff + BIN_WIDTH'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      month_ff <= month_in;
      temp_ff  <= temp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
      rd_ff <= mem[addr_ff];
   end

   mmms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cur.count),
      .quotient (quotient),
      .done     (div_done)
   );

   // quotient sign follows the sum since the count is positive
   assign mean_full = cur.sum[SUM_WIDTH-1] ? (~quotient + SUM_WIDTH'(1)) : quotient;

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = (state_ff == ST_EMIT);
   assign rsp_bin_index    = addr_ff;
   assign rsp_mean_temp    = (cur.count == '0) ? '0 : mean_full[TEMP_WIDTH-1:0];
   assign rsp_lowest_temp  = cur.low;
   assign rsp_highest_temp = cur.high;
   assign rsp_sample_count = cur.count;
   assign rsp_saturated    = cur.overflow;
   assign rsp_last_bin     = (addr_ff == BIN_WIDTH'(NUM_BINS - 1));

endmodule

`default_nettype wire
